>>> sv/nlb_pkg.sv
package nlb_pkg;

    localparam int MAX_ATOMS_DEF     = 1024;
    localparam int MAX_NEIGHBORS_DEF = 32;
    localparam int COORD_BITS_DEF    = 16;

    localparam int COUNT_W  = 11;
    localparam int BOX_W    = 16;
    localparam int CUTOFF_W = 32;
    localparam int IDX_W    = 10;
    localparam int POS_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ATOM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQ  = 3'd4;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic [BOX_W-1:0] x;
        logic [BOX_W-1:0] y;
        logic [BOX_W-1:0] z;
    } box_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SELF,
        ST_LATCH,
        ST_SCAN,
        ST_DRAIN
    } state_t;

endpackage

>>> sv/nlb_ram.sv
module nlb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/nlb_dist.sv
module nlb_dist #(
    parameter int COORD_BITS = nlb_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [nlb_pkg::IDX_W-1:0]         in_index,
    input  logic [3*COORD_BITS-1:0]           other,
    input  logic [3*COORD_BITS-1:0]           self_pos,
    input  nlb_pkg::box_t                     box,
    input  logic [nlb_pkg::CUTOFF_W-1:0]      cutoff_sq,
    output logic                              hit_valid,
    output logic [nlb_pkg::IDX_W-1:0]         hit_index,
    output logic                              busy
);

    import nlb_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int CMPW = (CB + 1 > BOX_W) ? CB + 1 : BOX_W;
    localparam int WW   = ((CB > BOX_W) ? CB : BOX_W) + 2;
    localparam int SW   = (2 * CB + 2 > CUTOFF_W + 1) ? 2 * CB + 2 : CUTOFF_W + 1;

    logic [BOX_W-1:0] box_arr [3];

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0]  i1_reg, i2_reg, i3_reg, i4_reg;
    logic signed [CB:0] d1_reg [3];
    logic               c1_reg [3];
    logic [CB-1:0]      m2_reg [3];
    logic [2*CB-1:0]    sq3_reg [3];
    logic               hit4_reg;

    logic signed [CB:0] d1_next [3];
    logic               c1_next [3];
    logic [CB-1:0]      m2_next [3];
    logic [2*CB-1:0]    sq3_next [3];
    logic [SW-1:0]      sum;
    logic               hit4_next;

    assign box_arr[0] = box.x;
    assign box_arr[1] = box.y;
    assign box_arr[2] = box.z;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        logic signed [CB:0]   d;
        logic signed [CB:0]   dn;
        logic [CB-1:0]        mag;
        logic signed [WW-1:0] dw;
        logic signed [WW-1:0] bw;
        logic signed [WW-1:0] ww;
        logic signed [CB:0]   w;
        logic signed [CB:0]   wn;

        always_comb
        begin
            d   = $signed({1'b0, other[a*CB +: CB]}) - $signed({1'b0, self_pos[a*CB +: CB]});
            dn  = -d;
            mag = d[CB] ? dn[CB-1:0] : d[CB-1:0];
            d1_next[a] = d;
            c1_next[a] = CMPW'({mag, 1'b0}) > CMPW'(box_arr[a]);

            dw = WW'(d1_reg[a]);
            bw = $signed(WW'(box_arr[a]));
            if (!c1_reg[a])
            begin
                ww = dw;
            end
            else if (dw > 0)
            begin
                ww = dw - bw;
            end
            else
            begin
                ww = dw + bw;
            end
            w  = ww[CB:0];
            wn = -w;
            m2_next[a]  = w[CB] ? wn[CB-1:0] : w[CB-1:0];
            sq3_next[a] = m2_reg[a] * m2_reg[a];
        end
    end

    always_comb
    begin
        sum = SW'(sq3_reg[0]) + SW'(sq3_reg[1]) + SW'(sq3_reg[2]);
        hit4_next = v3_reg && (sum < SW'(cutoff_sq));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            hit4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            hit4_reg <= hit4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i1_reg <= in_index;
            i2_reg <= i1_reg;
            i3_reg <= i2_reg;
            i4_reg <= i3_reg;
            for (int a = 0; a < 3; a++)
            begin
                d1_reg[a]  <= d1_next[a];
                c1_reg[a]  <= c1_next[a];
                m2_reg[a]  <= m2_next[a];
                sq3_reg[a] <= sq3_next[a];
            end
        end
    end

    assign hit_valid = v4_reg && hit4_reg;
    assign hit_index = i4_reg;
    assign busy      = v1_reg || v2_reg || v3_reg || v4_reg;

endmodule

>>> sv/periodic_neighbor_list_builder_core.sv
// Minimum-image neighbor list builder. A load word (command 0) writes one atom
// position into the store. A query word (command 1) reads the named atom,
// then streams every other slot below atom_count (capped at MAX_ATOMS)
// through the single read port of the position store at one pair per cycle
// while the output is not stalled.
// Hits come out in ascending index order, capped at MAX_NEIGHBORS; the final
// word of a query has last set, and truncated if further hits were dropped.
// A query with no hit yields one word with found clear. The input is taken
// again as soon as the final word of a query sits in the output register.
module periodic_neighbor_list_builder_core #(
    parameter int MAX_ATOMS     = nlb_pkg::MAX_ATOMS_DEF,
    parameter int MAX_NEIGHBORS = nlb_pkg::MAX_NEIGHBORS_DEF,
    parameter int COORD_BITS    = nlb_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [nlb_pkg::IDX_W-1:0]       atom_index,
    input  logic [nlb_pkg::POS_W-1:0]       pos_x,
    input  logic [nlb_pkg::POS_W-1:0]       pos_y,
    input  logic [nlb_pkg::POS_W-1:0]       pos_z,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [nlb_pkg::IDX_W-1:0]       neighbor_index,
    output logic                            found,
    output logic                            last,
    output logic                            truncated,
    input  logic                            cfg_we,
    input  logic [nlb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nlb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import nlb_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int AW  = $clog2(MAX_ATOMS);
    localparam int NCW = $clog2(MAX_NEIGHBORS + 1);

    function automatic logic [AW-1:0] slot_of(input logic [IDX_W-1:0] idx);
        int unsigned v;
        int unsigned m;
        v = 32'(idx);
        for (int k = 7; k >= 0; k--)
        begin
            m = 32'(MAX_ATOMS) << k;
            if (m < (32'd1 << IDX_W) && v >= m)
            begin
                v = v - m;
            end
        end
        return AW'(v);
    endfunction

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]  atom_count_reg;
    box_t                box_reg;
    logic [CUTOFF_W-1:0] cutoff_reg;

    logic [AW-1:0]       slot_reg, slot_next;
    logic [COUNT_W-1:0]  limit_reg, limit_next;
    logic [COUNT_W-1:0]  j_reg, j_next;
    logic [3*CB-1:0]     self_reg;
    logic                v1_reg, v1_next;
    logic [IDX_W-1:0]    i1_reg, i1_next;
    logic [NCW-1:0]      cnt_reg, cnt_next;
    logic                trunc_reg, trunc_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;

    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    out_idx_reg, out_idx_next;
    logic                out_found_reg, out_found_next;
    logic                out_last_reg, out_last_next;
    logic                out_trunc_reg, out_trunc_next;

    logic                adv;
    logic                ram_we;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [3*CB-1:0]     ram_rdata;
    logic                hit_valid;
    logic [IDX_W-1:0]    hit_index;
    logic                dist_busy;

    nlb_ram #(
        .WIDTH (3 * CB),
        .DEPTH (MAX_ATOMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_of(atom_index)),
        .wdata ({CB'(pos_z), CB'(pos_y), CB'(pos_x)}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nlb_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v1_reg),
        .in_index  (i1_reg),
        .other     (ram_rdata),
        .self_pos  (self_reg),
        .box       (box_reg),
        .cutoff_sq (cutoff_reg),
        .hit_valid (hit_valid),
        .hit_index (hit_index),
        .busy      (dist_busy)
    );

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atom_count_reg <= '0;
            box_reg        <= '{x: '1, y: '1, z: '1};
            cutoff_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ATOM_COUNT: atom_count_reg <= cfg_data[COUNT_W-1:0];
                REG_BOX_X:      box_reg.x      <= cfg_data[BOX_W-1:0];
                REG_BOX_Y:      box_reg.y      <= cfg_data[BOX_W-1:0];
                REG_BOX_Z:      box_reg.z      <= cfg_data[BOX_W-1:0];
                REG_CUTOFF_SQ:  cutoff_reg     <= cfg_data[CUTOFF_W-1:0];
                default:        ;
            endcase
        end
    end

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        limit_next      = limit_reg;
        j_next          = j_reg;
        v1_next         = v1_reg;
        i1_next         = i1_reg;
        cnt_next        = cnt_reg;
        trunc_next      = trunc_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg;
        out_idx_next    = out_idx_reg;
        out_found_next  = out_found_reg;
        out_last_next   = out_last_reg;
        out_trunc_next  = out_trunc_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = slot_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (adv)
        begin
            v1_next = 1'b0;
        end

        // a new hit under the cap retires the held one with last clear, else marks truncation
        if (adv && hit_valid)
        begin
            if (cnt_reg < NCW'(MAX_NEIGHBORS))
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = pend_idx_reg;
                    out_found_next = 1'b1;
                    out_last_next  = 1'b0;
                    out_trunc_next = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_idx_next   = hit_index;
                cnt_next        = cnt_reg + NCW'(1);
            end
            else
            begin
                trunc_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_LOAD)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        slot_next  = slot_of(atom_index);
                        limit_next = (32'(atom_count_reg) > 32'(MAX_ATOMS)) ?
                                     COUNT_W'(MAX_ATOMS) : atom_count_reg;
                        j_next     = '0;
                        cnt_next   = '0;
                        trunc_next = 1'b0;
                        state_next = ST_SELF;
                    end
                end
            end
            ST_SELF:
            begin
                ram_re     = 1'b1;
                ram_raddr  = slot_reg;
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (adv)
                begin
                    if (j_reg == limit_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(j_reg);
                        v1_next   = (AW'(j_reg) != slot_reg);
                        i1_next   = IDX_W'(j_reg);
                        j_next    = j_reg + COUNT_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (adv && !v1_reg && !dist_busy)
                begin
                    out_valid_next  = 1'b1;
                    out_idx_next    = pend_valid_reg ? pend_idx_reg : '0;
                    out_found_next  = pend_valid_reg;
                    out_last_next   = 1'b1;
                    out_trunc_next  = pend_valid_reg && trunc_reg;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            v1_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            trunc_reg      <= 1'b0;
            j_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            v1_reg         <= v1_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
            trunc_reg      <= trunc_next;
            j_reg          <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        limit_reg     <= limit_next;
        i1_reg        <= i1_next;
        pend_idx_reg  <= pend_idx_next;
        out_idx_reg   <= out_idx_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
        out_trunc_reg <= out_trunc_next;
        if (state_reg == ST_LATCH)
        begin
            self_reg <= ram_rdata;
        end
    end

    assign out_valid      = out_valid_reg;
    assign neighbor_index = out_idx_reg;
    assign found          = out_found_reg;
    assign last           = out_last_reg;
    assign truncated      = out_trunc_reg;

endmodule

>>> sv/nlb_checker.sv
module nlb_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            command,
    input logic [nlb_pkg::IDX_W-1:0]       atom_index,
    input logic [nlb_pkg::POS_W-1:0]       pos_x,
    input logic [nlb_pkg::POS_W-1:0]       pos_y,
    input logic [nlb_pkg::POS_W-1:0]       pos_z,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [nlb_pkg::IDX_W-1:0]       neighbor_index,
    input logic                            found,
    input logic                            last,
    input logic                            truncated,
    input logic                            cfg_we,
    input logic [nlb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [nlb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import nlb_pkg::*;

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(neighbor_index) &&
        $stable(found) && $stable(last) && $stable(truncated))
        else $error("output word changed while stalled");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> last && !truncated && neighbor_index == '0)
        else $error("empty word malformed");

    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truncated |-> last && found)
        else $error("truncated on non-final word");

    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_LOAD |=> in_ready)
        else $error("load word blocked input");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_QUERY |=> !in_ready)
        else $error("query word did not start a scan");

endmodule

bind periodic_neighbor_list_builder_core nlb_checker u_nlb_checker (.*);
